FILE: sv/sis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

    // fixed field widths and machine constants
    localparam int WORD_W      = 32;
    localparam int PTR_W       = 12;
    localparam int INSTR_BYTES = 16;
    localparam int WORD_BYTES  = 4;

    // item kinds
    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_READ = 2'd1,
        KIND_SETP = 2'd2,
        KIND_EXEC = 2'd3
    } kind_t;

    // shared adder operations
    typedef enum logic [1:0] {
        ALU_ADD   = 2'd0,
        ALU_SUB   = 2'd1,
        ALU_RNDUP = 2'd2
    } alu_op_t;

    // control group for the shared adder
    typedef struct packed {
        logic    go;
        alu_op_t op;
    } alu_ctl_t;

    // command item
    typedef struct packed {
        kind_t              kind;
        logic [PTR_W-1:0]   address;
        logic [WORD_W-1:0]  data;
    } sis_cmd_t;

    // response item
    typedef struct packed {
        logic [WORD_W-1:0]        read_data;
        logic [PTR_W-1:0]         pointer_out;
        logic                     branch_taken;
        logic signed [WORD_W-1:0] difference;
    } sis_rsp_t;

endpackage

`default_nettype wire

FILE: sv/sis_word_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_word_mem
    import sis_pkg::*;
#(
    parameter int MEM_WORDS = 1024,
    localparam int IDX_W = $clog2(MEM_WORDS)
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [IDX_W-1:0]  waddr,
    input  wire logic [WORD_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [IDX_W-1:0]  raddr,
    output logic      [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/sis_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_alu
    import sis_pkg::*;
(
    input  wire logic              clk,
    input  wire alu_ctl_t          ctl,
    input  wire logic [WORD_W-1:0] a,
    input  wire logic [WORD_W-1:0] b,
    output logic      [WORD_W-1:0] res
);

    logic [WORD_W-1:0] b_in;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] res_next;
    logic [WORD_W-1:0] res_reg;

    // one adder, subtract by inverting b with carry in
    always_comb
    begin
        b_in = (ctl.op == ALU_SUB) ? ~b : b;
        sum  = a + b_in + WORD_W'(ctl.op == ALU_SUB);
        case (ctl.op)
            ALU_ADD:   res_next = sum;
            ALU_SUB:   res_next = sum;
            ALU_RNDUP: res_next = sum & ~WORD_W'(INSTR_BYTES - 1);
            default:   res_next = sum;
        endcase
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (ctl.go)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: sv/sis_index.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_index
    import sis_pkg::*;
#(
    parameter int MEM_WORDS = 1024,
    localparam int IDX_W = $clog2(MEM_WORDS)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [WORD_W-1:0] byte_addr,
    output logic                   done,
    output logic      [IDX_W-1:0]  idx
);

    localparam bit IS_POW2 = (MEM_WORDS & (MEM_WORDS - 1)) == 0;

    generate
        if (IS_POW2)
        begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] idx_reg;

            // word index is a plain bit field
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= byte_addr[IDX_W+1:2];
                end
            end

            assign done = done_reg;
            assign idx  = idx_reg;
        end
        else
        begin : g_reduce
            localparam int VAL_W = WORD_W - 2;
            localparam int RCP_W = VAL_W - 4;
            localparam int PRD_W = VAL_W + RCP_W;
            // scaled reciprocal, the quotient estimate is low by at most one
            localparam logic [RCP_W-1:0] RCP = RCP_W'((64'd1 << VAL_W) / MEM_WORDS);
            localparam logic [IDX_W-1:0] MOD = IDX_W'(MEM_WORDS);

            logic             s1_reg;
            logic             s2_reg;
            logic             s3_reg;
            logic             done_reg;
            logic [VAL_W-1:0] val_reg;
            logic [RCP_W-1:0] quo_reg;
            logic [VAL_W-1:0] qm_reg;
            logic [IDX_W-1:0] rem_reg;
            logic [PRD_W-1:0] prod;
            logic [IDX_W:0]   trial;
            logic [IDX_W-1:0] rem_next;

            // quotient estimate, then one correcting subtract
            always_comb
            begin
                prod  = PRD_W'(val_reg) * PRD_W'(RCP);
                trial = (IDX_W + 1)'(val_reg - qm_reg);
                if (trial >= {1'b0, MOD})
                begin
                    rem_next = IDX_W'(trial - {1'b0, MOD});
                end
                else
                begin
                    rem_next = trial[IDX_W-1:0];
                end
            end

            // stage control
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    s1_reg   <= 1'b0;
                    s2_reg   <= 1'b0;
                    s3_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    s1_reg   <= start;
                    s2_reg   <= s1_reg;
                    s3_reg   <= s2_reg;
                    done_reg <= s3_reg;
                end
            end

            // remainder datapath
            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    val_reg <= byte_addr[WORD_W-1:2];
                end
                if (s1_reg)
                begin
                    quo_reg <= prod[PRD_W-1:VAL_W];
                end
                if (s2_reg)
                begin
                    qm_reg <= VAL_W'(VAL_W'(quo_reg) * VAL_W'(MOD));
                end
                if (s3_reg)
                begin
                    rem_reg <= rem_next;
                end
            end

            assign done = done_reg;
            assign idx  = rem_reg;
        end
    endgenerate

endmodule

`default_nettype wire

FILE: sv/subleq_instruction_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+----------------------------------------
// cmd      | in        | cmd_valid/cmd_stall | kind, address, data (sis_cmd_t)
// rsp      | out       | rsp_valid/rsp_stall | read_data, pointer_out, branch_taken,
//          |           |                     | difference (sis_rsp_t)
//
// one item at a time (set pointer, load, read or execute); with a MEM_WORDS
// that is not a power of two, each word access also passes through the
// multiply-based index reduction. execute is bound by the single memory
// port (six reads, one write in sequence) and the shared adder.
// reset clears the pointer and all control; memory contents are undefined.
// a new item is taken while the previous response still waits under rsp_stall;
// the block holds in its last step until the response register frees up.

module subleq_instruction_step_unit
    import sis_pkg::*;
#(
    parameter int MEM_WORDS = 1024
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cmd_valid,
    output logic          cmd_stall,
    input  wire sis_cmd_t cmd,
    output logic          rsp_valid,
    input  wire logic     rsp_stall,
    output sis_rsp_t      rsp
);

    localparam int IDX_W = $clog2(MEM_WORDS);

    // instruction word slots, in fetch order
    localparam logic [2:0] FW_OPA = 3'd0;
    localparam logic [2:0] FW_OPB = 3'd1;
    localparam logic [2:0] FW_TGT = 3'd2;
    localparam logic [2:0] FW_JMP = 3'd3;
    localparam logic [2:0] FW_A   = 3'd4;
    localparam logic [2:0] FW_B   = 3'd5;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_ADDR  = 11'b000_0000_0010,
        ST_IXGO  = 11'b000_0000_0100,
        ST_INDEX = 11'b000_0000_1000,
        ST_CAPT  = 11'b000_0001_0000,
        ST_SUB   = 11'b000_0010_0000,
        ST_TGO   = 11'b000_0100_0000,
        ST_TIDX  = 11'b000_1000_0000,
        ST_NEXT  = 11'b001_0000_0000,
        ST_PTR   = 11'b010_0000_0000,
        ST_DONE  = 11'b100_0000_0000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [2:0]        step_reg;
    logic [2:0]        step_next;
    logic [PTR_W-1:0]  ip_reg;
    logic [PTR_W-1:0]  ip_next;
    logic              rsp_valid_reg;
    logic              rsp_valid_next;

    kind_t             kind_reg;
    logic [PTR_W-1:0]  addr_reg;
    logic [WORD_W-1:0] data_reg;
    logic [WORD_W-1:0] fetch_reg [6];
    logic [WORD_W-1:0] rd_pend_reg;
    logic [WORD_W-1:0] diff_pend_reg;
    logic              taken_pend_reg;
    sis_rsp_t          rsp_reg;

    logic              cmd_fire;
    logic              done_fire;
    logic              taken_now;

    alu_ctl_t          alu_ctl;
    logic [WORD_W-1:0] alu_a;
    logic [WORD_W-1:0] alu_b;
    logic [WORD_W-1:0] alu_res;

    logic              ix_start;
    logic [WORD_W-1:0] ix_addr;
    logic              ix_done;
    logic [IDX_W-1:0]  ix_idx;

    logic              mem_we;
    logic [WORD_W-1:0] mem_wdata;
    logic              mem_re;
    logic [WORD_W-1:0] mem_rdata;

    // handshake
    assign cmd_stall = (state_reg != ST_IDLE);
    assign cmd_fire  = cmd_valid && (state_reg == ST_IDLE);
    assign done_fire = (state_reg == ST_DONE) && (!rsp_valid_reg || !rsp_stall);
    assign taken_now = (diff_pend_reg == '0) || diff_pend_reg[WORD_W-1];

    // shared adder operand select
    always_comb
    begin
        alu_ctl.go = 1'b0;
        alu_ctl.op = ALU_ADD;
        alu_a      = WORD_W'(ip_reg);
        alu_b      = WORD_W'(step_reg) * WORD_W'(WORD_BYTES);
        case (state_reg)
            ST_ADDR:
            begin
                alu_ctl.go = 1'b1;
            end
            ST_SUB:
            begin
                alu_ctl.go = 1'b1;
                alu_ctl.op = ALU_SUB;
                alu_a      = fetch_reg[FW_A];
                alu_b      = fetch_reg[FW_B];
            end
            ST_NEXT:
            begin
                alu_ctl.go = 1'b1;
                if (taken_now)
                begin
                    alu_ctl.op = ALU_RNDUP;
                    alu_a      = fetch_reg[FW_JMP];
                    alu_b      = WORD_W'(INSTR_BYTES - 1);
                end
                else
                begin
                    alu_b = WORD_W'(INSTR_BYTES);
                end
            end
            default:
            begin
                alu_ctl.go = 1'b0;
            end
        endcase
    end

    // index unit address select
    always_comb
    begin
        ix_start = (state_reg == ST_IXGO) || (state_reg == ST_TGO);
        if (state_reg == ST_TGO)
        begin
            ix_addr = fetch_reg[FW_TGT];
        end
        else if (kind_reg != KIND_EXEC)
        begin
            ix_addr = WORD_W'(addr_reg);
        end
        else if (step_reg == FW_A)
        begin
            ix_addr = fetch_reg[FW_OPA];
        end
        else if (step_reg == FW_B)
        begin
            ix_addr = fetch_reg[FW_OPB];
        end
        else
        begin
            ix_addr = alu_res;
        end
    end

    // memory port control
    always_comb
    begin
        mem_we = ix_done && (((state_reg == ST_INDEX) && (kind_reg == KIND_LOAD))
                             || (state_reg == ST_TIDX));
        mem_wdata = (state_reg == ST_TIDX) ? diff_pend_reg : data_reg;
        mem_re = ix_done && (state_reg == ST_INDEX) && (kind_reg != KIND_LOAD);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        ip_next        = ip_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire)
                begin
                    step_next = '0;
                    case (cmd.kind)
                        KIND_LOAD: state_next = ST_IXGO;
                        KIND_READ: state_next = ST_IXGO;
                        KIND_SETP:
                        begin
                            ip_next    = cmd.address;
                            state_next = ST_DONE;
                        end
                        KIND_EXEC: state_next = ST_ADDR;
                        default:   state_next = ST_DONE;
                    endcase
                end
            end
            ST_ADDR:  state_next = ST_IXGO;
            ST_IXGO:  state_next = ST_INDEX;
            ST_INDEX:
            begin
                if (ix_done)
                begin
                    state_next = (kind_reg == KIND_LOAD) ? ST_DONE : ST_CAPT;
                end
            end
            ST_CAPT:
            begin
                step_next = step_reg + 1'b1;
                if (kind_reg == KIND_READ)
                begin
                    state_next = ST_DONE;
                end
                else if (step_reg == FW_B)
                begin
                    state_next = ST_SUB;
                end
                else if (step_reg < FW_JMP)
                begin
                    state_next = ST_ADDR;
                end
                else
                begin
                    state_next = ST_IXGO;
                end
            end
            ST_SUB:   state_next = ST_TGO;
            ST_TGO:   state_next = ST_TIDX;
            ST_TIDX:
            begin
                if (ix_done)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:  state_next = ST_PTR;
            ST_PTR:
            begin
                ip_next    = alu_res[PTR_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (done_fire)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ip_reg        <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ip_reg        <= ip_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // item and working registers
    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            kind_reg       <= cmd.kind;
            addr_reg       <= cmd.address;
            data_reg       <= cmd.data;
            rd_pend_reg    <= '0;
            diff_pend_reg  <= '0;
            taken_pend_reg <= 1'b0;
        end
        if (state_reg == ST_CAPT)
        begin
            if (kind_reg == KIND_READ)
            begin
                rd_pend_reg <= mem_rdata;
            end
            else
            begin
                fetch_reg[step_reg] <= mem_rdata;
            end
        end
        if (state_reg == ST_TGO)
        begin
            diff_pend_reg <= alu_res;
        end
        if (state_reg == ST_NEXT)
        begin
            taken_pend_reg <= taken_now;
        end
        if (done_fire)
        begin
            rsp_reg.read_data    <= rd_pend_reg;
            rsp_reg.pointer_out  <= ip_reg;
            rsp_reg.branch_taken <= taken_pend_reg;
            rsp_reg.difference   <= $signed(diff_pend_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    sis_alu u_alu
    (
        .clk (clk),
        .ctl (alu_ctl),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    sis_index #(
        .MEM_WORDS (MEM_WORDS)
    ) u_index
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ix_start),
        .byte_addr (ix_addr),
        .done      (ix_done),
        .idx       (ix_idx)
    );

    sis_word_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ix_idx),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (ix_idx),
        .rdata (mem_rdata)
    );

    // memory is written only while an item is in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_IDLE))
        else $error("memory write outside an item");

    // the index unit only finishes while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        ix_done |-> ((state_reg == ST_INDEX) || (state_reg == ST_TIDX)))
        else $error("index result arrived in an unexpected state");

    // a taken branch always carries a non-positive difference
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp.branch_taken || (rsp.difference == '0)
                       || rsp.difference[WORD_W-1]))
        else $error("branch taken with positive difference");

    // a set pointer item goes straight to its response
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_fire && (cmd.kind == KIND_SETP)) |=> (state_reg == ST_DONE)
                                                  && (ip_reg == $past(cmd.address)))
        else $error("set pointer item not applied");

endmodule

`default_nettype wire
